// ----- rtl/tcc_pkg.sv -----
// Shared constants, payload types and stage map for the tetrahedron circumcenter unit.
package tcc_pkg;

  localparam int CW = 32;
  localparam int EW = CW + 1;
  localparam int MW = 2 * EW + 2;
  localparam int PW = 2 * MW;
  localparam int DW = 104;
  localparam int NW = PW;
  localparam int QB = 63;
  localparam int WW = DW + QB;

  localparam int MUL_LAT = 4;
  localparam int DIV_STEPS = QB;
  localparam int DIV_LAT = DIV_STEPS + 3;

  localparam int ST_E = 1;
  localparam int ST_CX = ST_E + MUL_LAT + 1;
  localparam int ST_SUM = ST_CX + MUL_LAT + 1;
  localparam int ST_DIV = ST_SUM + DIV_LAT;
  localparam int ST_OUT = ST_DIV + 1;

  localparam logic [CW-1:0] CMAX = {1'b0, {(CW - 1){1'b1}}};
  localparam logic [CW-1:0] CMIN = {1'b1, {(CW - 1){1'b0}}};

  typedef struct packed {
    logic signed [CW-1:0] a_x;
    logic signed [CW-1:0] a_y;
    logic signed [CW-1:0] a_z;
    logic signed [CW-1:0] b_x;
    logic signed [CW-1:0] b_y;
    logic signed [CW-1:0] b_z;
    logic signed [CW-1:0] c_x;
    logic signed [CW-1:0] c_y;
    logic signed [CW-1:0] c_z;
    logic signed [CW-1:0] d_x;
    logic signed [CW-1:0] d_y;
    logic signed [CW-1:0] d_z;
  } req_t;

  typedef struct packed {
    logic signed [CW-1:0] center_x;
    logic signed [CW-1:0] center_y;
    logic signed [CW-1:0] center_z;
    logic                 degenerate;
    logic                 saturated;
  } rsp_t;

  typedef struct packed {
    logic          neg;
    logic          big;
    logic [QB-2:0] mag;
  } div_res_t;

endpackage

// ----- rtl/tetrahedron_circumcenter_unit.sv -----
// Tetrahedron circumcenter: top level pipeline (edges, cross products, sums, divide, place).
// Throughput: one request per cycle; the whole pipeline advances when the result register
// is empty or being taken, and holds every stage otherwise.
// Depth is set by the 63-step restoring divider and the two four-stage multiplier levels.
// Reset (synchronous) clears all stage valid bits; data registers are not reset.
module tetrahedron_circumcenter_unit (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_ready,
  input  tcc_pkg::req_t   req_data,
  output logic            rsp_valid,
  input  logic            rsp_ready,
  output tcc_pkg::rsp_t   rsp_data
);
  import tcc_pkg::*;

  logic              en;
  logic [ST_OUT:1]   vld;

  logic signed [CW-1:0] pt  [4][3];
  logic signed [EW-1:0] e1  [3][3];
  logic signed [CW-1:0] a1  [3];
  logic signed [CW-1:0] ad  [ST_DIV-ST_E][3];
  logic signed [EW-1:0] e0d [ST_CX-ST_E][3];

  logic signed [PW-1:0] pm [3][3][2];
  logic signed [PW-1:0] ps [3][3];
  logic signed [MW-1:0] cx6 [3][3];
  logic signed [MW-1:0] sq6 [3];

  logic signed [PW-1:0] dm [3];
  logic signed [PW-1:0] nm [3][3];
  logic signed [PW-1:0] det_sum;
  logic signed [DW-1:0] det11;
  logic signed [NW-1:0] num11 [3];
  logic                 deg11;
  logic                 degd [DIV_LAT];

  div_res_t             dres [3];
  logic signed [QB:0]   v    [3];
  logic [CW-1:0]        ctr  [3];
  logic [2:0]           sat;

  assign en        = ~vld[ST_OUT] | rsp_ready;
  assign req_ready = en;
  assign rsp_valid = vld[ST_OUT];

  assign pt[0][0] = req_data.a_x;
  assign pt[0][1] = req_data.a_y;
  assign pt[0][2] = req_data.a_z;
  assign pt[1][0] = req_data.b_x;
  assign pt[1][1] = req_data.b_y;
  assign pt[1][2] = req_data.b_z;
  assign pt[2][0] = req_data.c_x;
  assign pt[2][1] = req_data.c_y;
  assign pt[2][2] = req_data.c_z;
  assign pt[3][0] = req_data.d_x;
  assign pt[3][1] = req_data.d_y;
  assign pt[3][2] = req_data.d_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[ST_OUT-1:1], req_valid};
    end
  end

  // edge vectors and side pipes
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        a1[k] <= pt[0][k];
        for (int i = 0; i < 3; i++) begin
          e1[i][k] <= EW'(pt[i+1][k]) - EW'(pt[0][k]);
        end
        ad[0][k]  <= a1[k];
        e0d[0][k] <= e1[0][k];
        for (int j = 1; j < ST_DIV - ST_E; j++) begin
          ad[j][k] <= ad[j-1][k];
        end
        for (int j = 1; j < ST_CX - ST_E; j++) begin
          e0d[j][k] <= e0d[j-1][k];
        end
      end
      degd[0] <= deg11;
      for (int j = 1; j < DIV_LAT; j++) begin
        degd[j] <= degd[j-1];
      end
    end
  end

  // cross products and squared lengths
  for (genvar i = 0; i < 3; i++) begin : g_l1
    for (genvar k = 0; k < 3; k++) begin : g_c
      tcc_mul u_m0 (
        .clk(clk), .en(en),
        .a(MW'(e1[(i+1)%3][(k+1)%3])), .b(MW'(e1[(i+2)%3][(k+2)%3])),
        .p(pm[i][k][0])
      );
      tcc_mul u_m1 (
        .clk(clk), .en(en),
        .a(MW'(e1[(i+1)%3][(k+2)%3])), .b(MW'(e1[(i+2)%3][(k+1)%3])),
        .p(pm[i][k][1])
      );
      tcc_mul u_sq (
        .clk(clk), .en(en),
        .a(MW'(e1[i][k])), .b(MW'(e1[i][k])),
        .p(ps[i][k])
      );
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        for (int k = 0; k < 3; k++) begin
          cx6[i][k] <= MW'(pm[i][k][0] - pm[i][k][1]);
        end
        sq6[i] <= MW'(ps[i][0] + ps[i][1] + ps[i][2]);
      end
    end
  end

  // triple product and numerator terms
  for (genvar k = 0; k < 3; k++) begin : g_l2
    tcc_mul u_det (
      .clk(clk), .en(en),
      .a(MW'(e0d[ST_CX-ST_E-1][k])), .b(cx6[0][k]),
      .p(dm[k])
    );
    for (genvar i = 0; i < 3; i++) begin : g_n
      tcc_mul u_num (
        .clk(clk), .en(en),
        .a(cx6[i][k]), .b(sq6[i]),
        .p(nm[k][i])
      );
    end
  end

  assign det_sum = dm[0] + dm[1] + dm[2];

  always_ff @(posedge clk) begin
    if (en) begin
      det11 <= DW'(det_sum <<< 1);
      deg11 <= det_sum == '0;
      for (int k = 0; k < 3; k++) begin
        num11[k] <= nm[k][0] + nm[k][1] + nm[k][2];
      end
    end
  end

  for (genvar k = 0; k < 3; k++) begin : g_div
    tcc_div u_div (
      .clk(clk), .en(en),
      .num(num11[k]), .den(det11),
      .res(dres[k])
    );
  end

  // offset placement and clamp
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      v[k]   = dres[k].neg
             ? (QB + 1)'(ad[ST_DIV-ST_E-1][k]) - $signed({2'b00, dres[k].mag})
             : (QB + 1)'(ad[ST_DIV-ST_E-1][k]) + $signed({2'b00, dres[k].mag});
      sat[k] = 1'b0;
      ctr[k] = v[k][CW-1:0];
      if (degd[DIV_LAT-1]) begin
        ctr[k] = ad[ST_DIV-ST_E-1][k];
      end else if (dres[k].big) begin
        sat[k] = 1'b1;
        ctr[k] = dres[k].neg ? CMIN : CMAX;
      end else if (!((&v[k][QB:CW-1]) | ~(|v[k][QB:CW-1]))) begin
        sat[k] = 1'b1;
        ctr[k] = v[k][QB] ? CMIN : CMAX;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rsp_data.center_x   <= ctr[0];
      rsp_data.center_y   <= ctr[1];
      rsp_data.center_z   <= ctr[2];
      rsp_data.degenerate <= degd[DIV_LAT-1];
      rsp_data.saturated  <= |sat;
    end
  end

endmodule

// ----- rtl/tcc_mul.sv -----
// Four-stage signed multiplier built from 34x34 partial products.
module tcc_mul (
  input  logic                       clk,
  input  logic                       en,
  input  logic signed [tcc_pkg::MW-1:0] a,
  input  logic signed [tcc_pkg::MW-1:0] b,
  output logic signed [tcc_pkg::PW-1:0] p
);
  import tcc_pkg::*;

  localparam int HW = MW / 2;

  logic          neg1, neg2, neg3;
  logic [MW-1:0] ma, mb;
  logic [MW-1:0] pll, plh, phl, phh;
  logic [PW-1:0] sum;

  always_ff @(posedge clk) begin
    if (en) begin
      neg1 <= a[MW-1] ^ b[MW-1];
      ma   <= a[MW-1] ? MW'(-a) : MW'(a);
      mb   <= b[MW-1] ? MW'(-b) : MW'(b);
      neg2 <= neg1;
      pll  <= ma[HW-1:0] * mb[HW-1:0];
      plh  <= ma[HW-1:0] * mb[MW-1:HW];
      phl  <= ma[MW-1:HW] * mb[HW-1:0];
      phh  <= ma[MW-1:HW] * mb[MW-1:HW];
      neg3 <= neg2;
      sum  <= PW'(pll) + (PW'(plh) << HW) + (PW'(phl) << HW) + (PW'(phh) << (2 * HW));
      p    <= neg3 ? -$signed(sum) : $signed(sum);
    end
  end

endmodule

// ----- rtl/tcc_div.sv -----
// Pipelined restoring divider: rounded quotient magnitude with overflow flag.
module tcc_div (
  input  logic                          clk,
  input  logic                          en,
  input  logic signed [tcc_pkg::NW-1:0] num,
  input  logic signed [tcc_pkg::DW-1:0] den,
  output tcc_pkg::div_res_t             res
);
  import tcc_pkg::*;

  logic [NW-1:0] na;
  logic [DW-1:0] da;
  logic          nga;

  logic [NW-1:0] rem [DIV_STEPS+1];
  logic [DW-1:0] dv  [DIV_STEPS+1];
  logic [QB-1:0] quo [DIV_STEPS+1];
  logic          ng  [DIV_STEPS+1];
  logic          bg  [DIV_STEPS+1];

  logic          up;
  logic [QB:0]   q2;

  always_ff @(posedge clk) begin
    if (en) begin
      na     <= num[NW-1] ? NW'(-num) : NW'(num);
      da     <= den[DW-1] ? DW'(-den) : DW'(den);
      nga    <= num[NW-1] ^ den[DW-1];
      rem[0] <= na;
      dv[0]  <= da;
      quo[0] <= '0;
      ng[0]  <= nga;
      bg[0]  <= WW'(na) >= (WW'(da) << QB);
    end
  end

  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_step
    localparam int K = QB - 1 - j;
    logic [WW:0] trial;
    assign trial = {1'b0, WW'(rem[j])} - {1'b0, WW'(dv[j]) << K};
    always_ff @(posedge clk) begin
      if (en) begin
        if (!trial[WW]) begin
          rem[j+1] <= trial[NW-1:0];
          quo[j+1] <= quo[j] | (QB'(1) << K);
        end else begin
          rem[j+1] <= rem[j];
          quo[j+1] <= quo[j];
        end
        dv[j+1] <= dv[j];
        ng[j+1] <= ng[j];
        bg[j+1] <= bg[j];
      end
    end
  end

  assign up = {rem[DIV_STEPS], 1'b0} >= (NW + 1)'(dv[DIV_STEPS]);
  assign q2 = (QB + 1)'(quo[DIV_STEPS]) + (QB + 1)'(up);

  always_ff @(posedge clk) begin
    if (en) begin
      res.neg <= ng[DIV_STEPS];
      res.big <= bg[DIV_STEPS] | (q2[QB:QB-1] != 2'b00);
      res.mag <= q2[QB-2:0];
    end
  end

endmodule

// ----- rtl/tcc_checker.sv -----
// Port-level assertions for the circumcenter unit, bound to the top level.
module tcc_checker (
  input logic          clk,
  input logic          rst,
  input logic          req_valid,
  input logic          req_ready,
  input logic          rsp_valid,
  input logic          rsp_ready,
  input tcc_pkg::rsp_t rsp_data
);
  import tcc_pkg::*;

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
    else $error("result changed while stalled");

  a_ready_when_empty: assert property (@(posedge clk)
    !rsp_valid |-> req_ready)
    else $error("request refused with empty output");

  a_deg_not_sat: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_data.degenerate |-> !rsp_data.saturated)
    else $error("degenerate result flagged saturated");

  a_reset_empty: assert property (@(posedge clk)
    !rst && $past(rst) |-> !rsp_valid)
    else $error("result valid right after reset");

  a_no_early_rsp: assert property (@(posedge clk)
    $past(rst) && !req_valid |=> !rsp_valid)
    else $error("result appeared without a request");

endmodule

bind tetrahedron_circumcenter_unit tcc_checker u_chk (.*);

// ----- tb/sv/tb_top.sv -----
// Testbench for the tetrahedron circumcenter unit: random and directed tetrahedra, exact predictor.
`timescale 1ns / 1ps

module tb_top;
  import tcc_pkg::*;

  localparam int LATENCY = 78;
  localparam int WDOG_LIMIT = 20000;
  localparam int N_RANDOM = 1630;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  req_t req_data = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp_data;

  tetrahedron_circumcenter_unit u_top (
    .clk(clk), .rst(rst), .req_valid(req_valid), .req_ready(req_ready),
    .req_data(req_data), .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
    .rsp_data(rsp_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  req_t pending_reqs[$];
  rsp_t expected_centers[$];
  int errors = 0;
  int n_sent = 0;
  int n_recv = 0;
  int n_degen = 0;
  int n_sat = 0;
  int hold_off = 0;
  bit src_pause = 1'b0;
  bit no_idle = 1'b0;
  int quiet_cycles = 0;

  typedef logic signed [255:0] wide_t;

  // a + round(num/den), ties away from zero, clamped to the coordinate range
  function automatic logic signed [CW-1:0] place_coord(logic signed [CW-1:0] a,
      wide_t num, wide_t den, inout bit sat);
    wide_t n, d, q, r, v;
    bit neg;
    neg = (num < 0) != (den < 0);
    n = (num < 0) ? -num : num;
    d = (den < 0) ? -den : den;
    q = n / d;
    r = n % d;
    if (2 * r >= d) q = q + 1;
    v = neg ? -q : q;
    v = v + a;
    if (v > wide_t'(signed'(CMAX)) ) begin
      sat = 1'b1;
      return CMAX;
    end
    if (v < wide_t'(signed'(CMIN))) begin
      sat = 1'b1;
      return CMIN;
    end
    return v[CW-1:0];
  endfunction

  function automatic rsp_t circumcenter(req_t t);
    wide_t e[3][3];
    wide_t cx[3][3];
    wide_t sq[3];
    wide_t det, num;
    wide_t p0[3];
    int u, w;
    bit sat;
    rsp_t r;
    sat = 1'b0;
    p0[0] = t.a_x; p0[1] = t.a_y; p0[2] = t.a_z;
    e[0][0] = wide_t'(t.b_x) - p0[0]; e[0][1] = wide_t'(t.b_y) - p0[1];
    e[0][2] = wide_t'(t.b_z) - p0[2];
    e[1][0] = wide_t'(t.c_x) - p0[0]; e[1][1] = wide_t'(t.c_y) - p0[1];
    e[1][2] = wide_t'(t.c_z) - p0[2];
    e[2][0] = wide_t'(t.d_x) - p0[0]; e[2][1] = wide_t'(t.d_y) - p0[1];
    e[2][2] = wide_t'(t.d_z) - p0[2];
    for (int i = 0; i < 3; i++) begin
      u = (i + 1) % 3;
      w = (i + 2) % 3;
      cx[i][0] = e[u][1] * e[w][2] - e[u][2] * e[w][1];
      cx[i][1] = e[u][2] * e[w][0] - e[u][0] * e[w][2];
      cx[i][2] = e[u][0] * e[w][1] - e[u][1] * e[w][0];
      sq[i] = e[i][0] * e[i][0] + e[i][1] * e[i][1] + e[i][2] * e[i][2];
    end
    det = 2 * (e[0][0] * cx[0][0] + e[0][1] * cx[0][1] + e[0][2] * cx[0][2]);
    r = '0;
    if (det == 0) begin
      r.center_x = t.a_x;
      r.center_y = t.a_y;
      r.center_z = t.a_z;
      r.degenerate = 1'b1;
      return r;
    end
    num = cx[0][0] * sq[0] + cx[1][0] * sq[1] + cx[2][0] * sq[2];
    r.center_x = place_coord(t.a_x, num, det, sat);
    num = cx[0][1] * sq[0] + cx[1][1] * sq[1] + cx[2][1] * sq[2];
    r.center_y = place_coord(t.a_y, num, det, sat);
    num = cx[0][2] * sq[0] + cx[1][2] * sq[1] + cx[2][2] * sq[2];
    r.center_z = place_coord(t.a_z, num, det, sat);
    r.saturated = sat;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [CW-1:0] got, logic [CW-1:0] want);
    errors++;
    $display("MISMATCH request %0d %s: got %h want %h", n_recv, what, got, want);
  endtask

  task automatic queue_req(req_t t);
    pending_reqs.insert(pending_reqs.size(), t);
  endtask

  function automatic logic [CW-1:0] rand_coord(int mode);
    case (mode)
      0: return $urandom();
      1: return $urandom_range(0, 2 ** 20) - 2 ** 19;
      2: return $urandom_range(0, 2 ** 26) - 2 ** 25;
      default: return $urandom_range(0, 64) - 32;
    endcase
  endfunction

  function automatic req_t rand_tet();
    req_t t;
    int mode;
    logic [CW-1:0] base[3];
    mode = $urandom_range(0, 3);
    for (int k = 0; k < 3; k++) base[k] = ($urandom_range(0, 3) == 0) ? $urandom() : '0;
    t.a_x = base[0] + rand_coord(mode); t.a_y = base[1] + rand_coord(mode);
    t.a_z = base[2] + rand_coord(mode);
    t.b_x = base[0] + rand_coord(mode); t.b_y = base[1] + rand_coord(mode);
    t.b_z = base[2] + rand_coord(mode);
    t.c_x = base[0] + rand_coord(mode); t.c_y = base[1] + rand_coord(mode);
    t.c_z = base[2] + rand_coord(mode);
    if ($urandom_range(0, 9) == 0) begin
      // coplanar: d on the line through a and b
      t.d_x = 2 * t.b_x - t.a_x; t.d_y = 2 * t.b_y - t.a_y; t.d_z = 2 * t.b_z - t.a_z;
    end else begin
      t.d_x = base[0] + rand_coord(mode); t.d_y = base[1] + rand_coord(mode);
      t.d_z = base[2] + rand_coord(mode);
    end
    return t;
  endfunction

  function automatic req_t make_tet(int ax, int ay, int az, int bx, int by, int bz,
      int cx_, int cy, int cz, int dx, int dy, int dz);
    req_t t;
    t.a_x = ax; t.a_y = ay; t.a_z = az; t.b_x = bx; t.b_y = by; t.b_z = bz;
    t.c_x = cx_; t.c_y = cy; t.c_z = cz; t.d_x = dx; t.d_y = dy; t.d_z = dz;
    return t;
  endfunction

  initial begin
    int one;
    one = 1 << 16;
    queue_req(make_tet(0, 0, 0, one, 0, 0, 0, one, 0, 0, 0, one));
    queue_req(make_tet(0, 0, 0, 1, 0, 0, 0, 1, 0, 0, 0, 1));
    queue_req(make_tet(0, 0, 0, 3, 0, 0, 0, 1, 0, 0, 0, 1));
    queue_req(make_tet(5, 5, 5, 5, 5, 5, 5, 5, 5, 5, 5, 5));
    queue_req(make_tet(0, 0, 0, one, 0, 0, 2 * one, 0, 0, 0, one, 0));
    queue_req(make_tet(CMAX, CMAX, CMAX, CMIN, CMIN, CMIN, CMAX, CMIN, CMAX,
                       CMIN, CMAX, CMIN));
    queue_req(make_tet(CMAX, CMAX, CMAX, CMAX - 1, CMAX, CMAX, CMAX, CMAX - 1,
                       CMAX, CMAX, CMAX, CMAX - 1));
    queue_req(make_tet(CMIN, CMIN, CMIN, CMIN + 1, CMIN, CMIN, CMIN, CMIN + 1,
                       CMIN, CMIN, CMIN, CMIN + 1));
    queue_req(make_tet(0, 0, 0, 1, 0, 0, 0, 1, 0, 1, 1, 1));
    queue_req(make_tet(0, 0, 0, CMAX, 0, 0, 0, 1, 0, 0, 0, 1));
    queue_req(make_tet(-one, -one, -one, one, -one, -one, -one, one, -one,
                       -one, -one, one));
    queue_req(make_tet(0, 0, 0, 1, 0, 0, 0, 1, 0, 0, 0, -1));
    queue_req(make_tet(0, 0, 0, 0, 0, 0, 1, 2, 3, 4, 5, 6));
    queue_req(make_tet(-1, -1, -1, 0, 0, 0, -1, 0, 0, 0, -1, 0));
    queue_req(make_tet(CMAX, 0, CMIN, CMAX, 1, CMIN, CMAX, 0, CMIN + 1,
                       CMAX - 1, 0, CMIN));
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    wait (pending_reqs.size() == 0);
    wait (expected_centers.size() == 0);
    src_pause = 1'b1;
    hold_off = 400;
    for (int i = 0; i < 200; i++) queue_req(rand_tet());
    src_pause = 1'b0;
    wait (hold_off == 0 && pending_reqs.size() == 0);
    src_pause = 1'b1;
    wait (expected_centers.size() == 0);
    src_pause = 1'b0;
    no_idle = 1'b1;
    for (int i = 0; i < 400; i++) queue_req(rand_tet());
    wait (pending_reqs.size() == 0);
    no_idle = 1'b0;
    for (int i = 0; i < N_RANDOM - 600; i++) queue_req(rand_tet());
    wait (pending_reqs.size() == 0 && !req_valid);
    wait (expected_centers.size() == 0);
    repeat (LATENCY + 10) @(posedge clk);
    $display("Checked %0d of %0d tetrahedra: %0d degenerate, %0d saturated.",
             n_recv, n_sent, n_degen, n_sat);
    $display("Covered directed extremes, backpressure fill and drain, and random streams.");
    if (errors == 0 && expected_centers.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      if (req_valid && req_ready) begin
        expected_centers.insert(expected_centers.size(), circumcenter(req_data));
        n_sent++;
      end
      if (!req_valid || req_ready) begin
        if (pending_reqs.size() > 0 && !src_pause &&
            (no_idle || $urandom_range(0, 99) >= 6)) begin
          req_valid <= 1'b1;
          req_data <= pending_reqs.pop_front();
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    rsp_t want;
    if (rst) begin
      rsp_ready <= 1'b0;
    end else begin
      if (rsp_valid && rsp_ready) begin
        if (expected_centers.size() == 0) begin
          report_mismatch("unexpected result", rsp_data.center_x, '0);
        end else begin
          want = expected_centers.pop_front();
          if (rsp_data.center_x !== want.center_x)
            report_mismatch("center_x", rsp_data.center_x, want.center_x);
          if (rsp_data.center_y !== want.center_y)
            report_mismatch("center_y", rsp_data.center_y, want.center_y);
          if (rsp_data.center_z !== want.center_z)
            report_mismatch("center_z", rsp_data.center_z, want.center_z);
          if (rsp_data.degenerate !== want.degenerate)
            report_mismatch("degenerate", rsp_data.degenerate, want.degenerate);
          if (rsp_data.saturated !== want.saturated)
            report_mismatch("saturated", rsp_data.saturated, want.saturated);
          n_degen += want.degenerate;
          n_sat += want.saturated;
        end
        n_recv++;
      end
      if (hold_off > 0) begin
        hold_off <= hold_off - 1;
        rsp_ready <= 1'b0;
      end else begin
        rsp_ready <= no_idle || $urandom_range(0, 99) >= 6;
      end
    end
  end

  always @(posedge clk) begin
    if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || hold_off > 0) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WDOG_LIMIT) begin
        $display("Timeout after %0d idle cycles", quiet_cycles);
        $display("Verification failed");
        $finish;
      end
    end
  end

endmodule

// ----- tetrahedron_circumcenter_unit.f -----
rtl/tcc_pkg.sv
rtl/tcc_mul.sv
rtl/tcc_div.sv
rtl/tetrahedron_circumcenter_unit.sv
rtl/tcc_checker.sv
tb/sv/tb_top.sv
